>>> rtl/core/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and constants of the affine bilinear sampler.
// ----------------------------------------------------------------------------
package abs_pkg;

   typedef enum logic [2:0] {
      CSR_COEF_XX     = 3'd0,
      CSR_COEF_XY     = 3'd1,
      CSR_COEF_X0     = 3'd2,
      CSR_COEF_YX     = 3'd3,
      CSR_COEF_YY     = 3'd4,
      CSR_COEF_Y0     = 3'd5,
      CSR_SOURCE_SIZE = 3'd6,
      CSR_SAMPLE_MODE = 3'd7
   } csr_index_type;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [31:0] COEF_ONE         = 32'h0001_0000;
   localparam logic [25:0] SOURCE_SIZE_INIT = 26'd8193;

   // reciprocal of 255 in Q.24, slightly low so the estimate never overshoots
   localparam logic [16:0] RECIP_255 = 17'h10101;

   typedef struct packed {
      logic        action;
      logic [15:0] texel_address;
      logic [31:0] texel_rgba;
      logic [11:0] dest_x;
      logic [11:0] dest_y;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] red_value;
      logic [16:0] green_value;
      logic [16:0] blue_value;
      logic [16:0] alpha_value;
      logic        inside_source;
   } rsp_payload_type;

   // per-stage advance strobes handed to the channel filters
   typedef struct packed {
      logic en_top;
      logic en_blend;
      logic en_scale;
   } filt_en_type;

endpackage

>>> rtl/core/affine_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// affine_bilinear_sampler_unit
// Texel store plus affine mapped bilinear sampler, nine register stages.
// ----------------------------------------------------------------------------
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   abs_pkg::req_payload_type
//   rsp       out   rsp_valid/rsp_stall   abs_pkg::rsp_payload_type
//   csr       in    csr_write             csr_index, csr_wdata
//
// One item per cycle unless rsp_stall backs up the pipeline.
// Four replicated texel memories each serve one of the four taps per cycle.
// Write items update every copy and give no result.
// Reset clears the pipeline valids and the config registers, not the texels.
// A stalled stage holds; empty stages ahead of it keep filling.
// TEXEL_COUNT must be a power of two; reads wrap modulo it.
module affine_bilinear_sampler_unit #(
   parameter int TEXEL_COUNT = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  abs_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output abs_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata
);
   import abs_pkg::*;

   localparam int AW = (TEXEL_COUNT > 1) ? $clog2(TEXEL_COUNT) : 1;
   localparam int NST = 9;

   logic signed [31:0] coef_xx_ff, coef_xy_ff, coef_x0_ff;
   logic signed [31:0] coef_yx_ff, coef_yy_ff, coef_y0_ff;
   logic        [25:0] source_size_ff;
   logic        [1:0]  sample_mode_ff;

   logic [NST:1] vld_ff, vld_in, en;

   // stage 1..4 payload carried for write items
   logic        act_ff [1:4];
   logic [15:0] wad_ff [1:4];
   logic [31:0] wdt_ff [1:4];

   logic signed [13:0] cx, cy;
   logic signed [45:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [47:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [47:0] sxm, sym;
   logic        [12:0] width, height, wm1, hm1;
   logic signed [13:0] x0, y0, xp1, yp1;
   logic        [12:0] xa_in, xb_in, ya_in, yb_in;
   logic        [12:0] xa_ff, xb_ff, ya_ff, yb_ff;
   logic        [16:0] dx3_ff, dy3_ff, dx4_ff, dy4_ff, dx5_ff, dy5_ff;
   logic               in3_in, in3_ff, in4_ff, in5_ff, in6_ff, in7_ff, in8_ff;
   logic        [24:0] ra_tl, ra_tr, ra_bl, ra_br;
   logic        [AW-1:0] ra_ff [4];
   logic               wr_ok4_ff;
   logic        [24:0] wa_full;
   logic        [31:0] rd_ff [4];
   logic               smp5_ff;
   filt_en_type        fen;
   logic        [16:0] chan_val [4];
   rsp_payload_type    rsp_ff, rsp_in;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff     <= COEF_ONE;
         coef_xy_ff     <= '0;
         coef_x0_ff     <= '0;
         coef_yx_ff     <= '0;
         coef_yy_ff     <= COEF_ONE;
         coef_y0_ff     <= '0;
         source_size_ff <= SOURCE_SIZE_INIT;
         sample_mode_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_XX:     coef_xx_ff     <= csr_wdata;
            CSR_COEF_XY:     coef_xy_ff     <= csr_wdata;
            CSR_COEF_X0:     coef_x0_ff     <= csr_wdata;
            CSR_COEF_YX:     coef_yx_ff     <= csr_wdata;
            CSR_COEF_YY:     coef_yy_ff     <= csr_wdata;
            CSR_COEF_Y0:     coef_y0_ff     <= csr_wdata;
            CSR_SOURCE_SIZE: source_size_ff <= csr_wdata[25:0];
            CSR_SAMPLE_MODE: sample_mode_ff <= csr_wdata[1:0];
         endcase
      end
   end

   // ------------------------------------------------------- valid / advance
   always_comb begin
      en[NST] = !vld_ff[NST] || !rsp_stall;
      for (int i = NST - 1; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[1] = req_valid;
      for (int i = 2; i <= NST; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
      // drop write items once the memories have taken them
      vld_in[6] = vld_ff[5] && smp5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= NST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !en[1];

   // ------------------------------------------------------- stage 1: products
   assign cx = {1'b0, req_data.dest_x, 1'b1};
   assign cy = {1'b0, req_data.dest_y, 1'b1};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pxx_ff    <= coef_xx_ff * cx;
         pxy_ff    <= coef_xy_ff * cy;
         pyx_ff    <= coef_yx_ff * cx;
         pyy_ff    <= coef_yy_ff * cy;
         act_ff[1] <= req_data.action;
         wad_ff[1] <= req_data.texel_address;
         wdt_ff[1] <= req_data.texel_rgba;
      end
   end

   // ---------------------------------------------------- stage 2: sum, Q.17
   assign sx_in = pxx_ff + pxy_ff + $signed({coef_x0_ff, 1'b0});
   assign sy_in = pyx_ff + pyy_ff + $signed({coef_y0_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         act_ff[2] <= act_ff[1];
         wad_ff[2] <= wad_ff[1];
         wdt_ff[2] <= wdt_ff[1];
      end
   end

   // ---------------------------------------- stage 3: bounds, split, clamp
   assign width  = source_size_ff[12:0];
   assign height = source_size_ff[25:13];
   assign wm1    = width - 13'd1;
   assign hm1    = height - 13'd1;
   assign sxm    = sx_ff - 48'sd65536;
   assign sym    = sy_ff - 48'sd65536;
   assign x0     = sxm[30:17];
   assign y0     = sym[30:17];
   assign xp1    = x0 + 14'sd1;
   assign yp1    = y0 + 14'sd1;

   always_comb begin
      in3_in = !sx_ff[47] && (sx_ff < $signed({18'b0, width, 17'b0}))
            && !sy_ff[47] && (sy_ff < $signed({18'b0, height, 17'b0}));
      xa_in  = x0[13] ? 13'd0 : x0[12:0];
      ya_in  = y0[13] ? 13'd0 : y0[12:0];
      xb_in  = (xp1 < $signed({1'b0, width}))  ? xp1[12:0] : wm1;
      yb_in  = (yp1 < $signed({1'b0, height})) ? yp1[12:0] : hm1;
      if (sample_mode_ff[0]) begin
         xa_in = wm1 - xa_in;
         xb_in = wm1 - xb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         xa_ff     <= xa_in;
         xb_ff     <= xb_in;
         ya_ff     <= ya_in;
         yb_ff     <= yb_in;
         dx3_ff    <= sxm[16:0];
         dy3_ff    <= sym[16:0];
         in3_ff    <= in3_in;
         act_ff[3] <= act_ff[2];
         wad_ff[3] <= wad_ff[2];
         wdt_ff[3] <= wdt_ff[2];
      end
   end

   // ----------------------------------------------------- stage 4: addresses
   assign ra_tl = 25'(ya_ff * width) + 25'(xa_ff);
   assign ra_tr = 25'(ya_ff * width) + 25'(xb_ff);
   assign ra_bl = 25'(yb_ff * width) + 25'(xa_ff);
   assign ra_br = 25'(yb_ff * width) + 25'(xb_ff);
   assign wa_full = 25'(wad_ff[4]);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         ra_ff[0]  <= ra_tl[AW-1:0];
         ra_ff[1]  <= ra_tr[AW-1:0];
         ra_ff[2]  <= ra_bl[AW-1:0];
         ra_ff[3]  <= ra_br[AW-1:0];
         dx4_ff    <= dx3_ff;
         dy4_ff    <= dy3_ff;
         in4_ff    <= in3_ff;
         wr_ok4_ff <= 25'(wad_ff[3]) < 25'(TEXEL_COUNT);
         act_ff[4] <= act_ff[3];
         wad_ff[4] <= wad_ff[3];
         wdt_ff[4] <= wdt_ff[3];
      end
   end

   // -------------------------------------------------- stage 5: texel memory
   for (genvar k = 0; k < 4; k++) begin : g_mem
      logic [31:0] mem [0:TEXEL_COUNT-1];
      always_ff @(posedge clock) begin
         if (en[5] && vld_ff[4] && act_ff[4] == ACTION_WRITE && wr_ok4_ff) begin
            mem[wa_full[AW-1:0]] <= wdt_ff[4];
         end
         if (en[5]) begin
            rd_ff[k] <= mem[ra_ff[k]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         dx5_ff  <= dx4_ff;
         dy5_ff  <= dy4_ff;
         in5_ff  <= in4_ff;
         smp5_ff <= act_ff[4] == ACTION_SAMPLE;
      end
   end

   // ------------------------------------------------ stages 6..8: filtering
   assign fen.en_top   = en[6];
   assign fen.en_blend = en[7];
   assign fen.en_scale = en[8];

   for (genvar c = 0; c < 4; c++) begin : g_chan
      abs_chan_filter u_filt (
         .clock     (clock),
         .en        (fen),
         .unit_mode (sample_mode_ff[1]),
         .tl        (rd_ff[0][8*c +: 8]),
         .tr        (rd_ff[1][8*c +: 8]),
         .bl        (rd_ff[2][8*c +: 8]),
         .br        (rd_ff[3][8*c +: 8]),
         .dx        (dx5_ff),
         .dy        (dy5_ff),
         .value     (chan_val[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en[6]) in6_ff <= in5_ff;
      if (en[7]) in7_ff <= in6_ff;
      if (en[8]) in8_ff <= in7_ff;
   end

   // ------------------------------------------------------ stage 9: result
   always_comb begin
      rsp_in.red_value     = in8_ff ? chan_val[0] : 17'd0;
      rsp_in.green_value   = in8_ff ? chan_val[1] : 17'd0;
      rsp_in.blue_value    = in8_ff ? chan_val[2] : 17'd0;
      rsp_in.alpha_value   = in8_ff ? chan_val[3] : 17'd0;
      rsp_in.inside_source = in8_ff;
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NST];
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------- assertions
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[1])
      else $error("accepted item did not enter the first stage");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] && !en[5] |=> vld_ff[5] && $stable(rd_ff[0]))
      else $error("stalled memory stage lost its item");

   a_outside_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.inside_source |->
         rsp_data.red_value == 17'd0 && rsp_data.alpha_value == 17'd0)
      else $error("outside sample has nonzero channels");

   a_byte_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sample_mode_ff[1] |->
         rsp_data.red_value <= 17'd255 && rsp_data.green_value <= 17'd255)
      else $error("byte mode result above 255");

endmodule

>>> rtl/core/abs_chan_filter.sv
// ----------------------------------------------------------------------------
// abs_chan_filter
// One color channel: horizontal lerp, vertical lerp, byte or unit scaling.
// ----------------------------------------------------------------------------
module abs_chan_filter (
   input  logic                 clock,
   input  abs_pkg::filt_en_type en,
   input  logic                 unit_mode,
   input  logic [7:0]           tl,
   input  logic [7:0]           tr,
   input  logic [7:0]           bl,
   input  logic [7:0]           br,
   input  logic [16:0]          dx,
   input  logic [16:0]          dy,
   output logic [16:0]          value
);
   import abs_pkg::*;

   logic signed [26:0] top_ff, top_in, bot_ff, bot_in;
   logic        [16:0] dy_ff;
   logic signed [44:0] v_ff, v_in;
   logic        [25:0] t_ff, t_in;
   logic        [17:0] q0_ff, q0_in;
   logic        [16:0] byte_ff, byte_in;
   logic        [43:0] uv;
   logic        [44:0] biased;
   logic        [42:0] qprod;
   logic        [25:0] rem;

   always_comb begin
      top_in = $signed({2'b0, tl, 17'b0})
             + 27'($signed({1'b0, tr}) - $signed({1'b0, tl})) * $signed({10'b0, dx});
      bot_in = $signed({2'b0, bl, 17'b0})
             + 27'($signed({1'b0, br}) - $signed({1'b0, bl})) * $signed({10'b0, dx});
   end

   always_comb begin
      v_in = $signed({1'b0, top_ff[26:0], 17'b0})
           + 45'($signed({bot_ff[26], bot_ff} - {top_ff[26], top_ff})) * $signed({28'b0, dy_ff});
   end

   always_comb begin
      uv      = v_ff[44] ? 44'd0 : v_ff[43:0];
      biased  = {1'b0, uv} + 45'(255 << 17);
      t_in    = biased[43:18];
      qprod   = 43'(t_in) * 43'(RECIP_255);
      q0_in   = qprod[41:24];
      byte_in = {7'b0, uv[43:34]};
   end

   // fix the reciprocal estimate by at most one
   always_comb begin
      rem = t_ff - ({q0_ff, 8'b0} - 26'(q0_ff));
      if (!unit_mode) begin
         value = byte_ff;
      end else if (rem >= 26'd255) begin
         value = 17'(q0_ff + 18'd1);
      end else begin
         value = q0_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.en_top) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         dy_ff  <= dy;
      end
      if (en.en_blend) begin
         v_ff <= v_in;
      end
      if (en.en_scale) begin
         t_ff    <= t_in;
         q0_ff   <= q0_in;
         byte_ff <= byte_in;
      end
   end

endmodule
